FILE: hdl/cwd_pkg.sv
package cwd_pkg;

  localparam int ATOM_SLOTS_DEF       = 1024;
  localparam int IMAGE_FIELD_BITS_DEF = 10;

  localparam int IDX_W     = 10;
  localparam int POS_W     = 32;
  localparam int IMG_W     = 30;
  localparam int CHG_W     = 24;
  localparam int GRP_W     = 32;
  localparam int LEN_W     = 31;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int OUT_W     = 64;
  localparam int VOL_W     = 93;
  localparam int MUL_W     = 33;

  localparam logic [OUT_W-1:0] TOP63 = 64'h8000_0000_0000_0000;
  localparam logic [OUT_W-1:0] MAX63 = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRICLINIC    = 3'd0,
    REG_GROUP_SELECT = 3'd1,
    REG_BOX_X        = 3'd2,
    REG_BOX_Y        = 3'd3,
    REG_BOX_Z        = 3'd4,
    REG_TILT_XY      = 3'd5,
    REG_TILT_XZ      = 3'd6,
    REG_TILT_YZ      = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SLOT, S_LOAD, S_MUL, S_ROOT, S_DIV, S_OUT
  } state_t;

  // Schedule of the shared multiplier. A product issued in one step is
  // accumulated during the next one.
  typedef enum logic [4:0] {
    STP_VXY  = 5'd0,
    STP_DX   = 5'd1,
    STP_V_LO = 5'd2,
    STP_V_HI = 5'd3,
    STP_DY   = 5'd4,
    STP_DZ   = 5'd5,
    STP_TXY  = 5'd6,
    STP_TXZ  = 5'd7,
    STP_TYZ  = 5'd8,
    STP_GAP  = 5'd9,
    STP_MAG  = 5'd10,
    STP_QXL  = 5'd11,
    STP_QXH  = 5'd12,
    STP_QYL  = 5'd13,
    STP_QYH  = 5'd14,
    STP_QZL  = 5'd15,
    STP_QZH  = 5'd16,
    STP_SXL  = 5'd17,
    STP_SXM  = 5'd18,
    STP_SXH  = 5'd19,
    STP_SYL  = 5'd20,
    STP_SYM  = 5'd21,
    STP_SYH  = 5'd22,
    STP_SZL  = 5'd23,
    STP_SZM  = 5'd24,
    STP_SZH  = 5'd25,
    STP_ROOT = 5'd26,
    STP_LL   = 5'd27,
    STP_LH   = 5'd28,
    STP_END  = 5'd29
  } mstep_t;

endpackage

FILE: hdl/charge_weighted_displacement.sv
// Charge weighted displacement unit.
// Requests enter on start while busy is low: command, atom_index, the wrapped
// position, the packed image word, charge and group bits. A record request
// stores the position as the slot's original and gives no result; it keeps
// busy high through the load state, after the index reduction when
// ATOM_SLOTS is below 1024. A compute request gives one result, shown for
// exactly one cycle with done high; the receiver cannot hold it off.
// The index reduction comes first for compute requests too. Unselected atoms
// skip the arithmetic and go from the load state straight to the output
// state. The work is done by one shared 33x33 multiplier running a 30 step
// schedule, a restoring square root retiring one result bit per cycle, and
// four restoring dividers that retire one quotient bit per cycle in
// parallel. One request is in flight at a time; start is taken again in the
// cycle that done is shown. The configuration port writes a register and
// must only be used while busy is low. Synchronous reset returns the control
// to idle and the configuration registers to their defaults; the position
// store is not cleared and a slot must be recorded before it is used.
module charge_weighted_displacement
  import cwd_pkg::*;
#(
  parameter int ATOM_SLOTS       = ATOM_SLOTS_DEF,
  parameter int IMAGE_FIELD_BITS = IMAGE_FIELD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    command,
  input  logic [IDX_W-1:0]        atom_index,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [POS_W-1:0] pos_z,
  input  logic [IMG_W-1:0]        image_word,
  input  logic signed [CHG_W-1:0] charge,
  input  logic [GRP_W-1:0]        atom_groups,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  output logic                    done,
  output logic [IDX_W-1:0]        out_index,
  output logic signed [OUT_W-1:0] qdisp_x,
  output logic signed [OUT_W-1:0] qdisp_y,
  output logic signed [OUT_W-1:0] qdisp_z,
  output logic [OUT_W-2:0]        qdisp_len
);

  localparam int AW    = (ATOM_SLOTS > 1) ? $clog2(ATOM_SLOTS) : 1;
  localparam int IFB   = IMAGE_FIELD_BITS;
  localparam int BW    = IFB + 1;
  localparam int DW    = IFB + 33;
  localparam int DMW   = IFB + 32;
  localparam int H     = (DMW + 1) / 2;
  localparam int LW    = DMW + 1;
  localparam int LH    = (LW + 1) / 2;
  localparam int SW    = 2 * LW;
  localparam int PW    = DMW + 25;
  localparam int RW    = VOL_W + 1;
  localparam int QW    = OUT_W - 1;
  localparam int CW    = IDX_W + 17;
  localparam int SCW   = $clog2(IDX_W);
  localparam int RCW   = $clog2(LW);
  localparam int DCW   = $clog2(QW + 1);
  localparam int IXW   = 3 * IFB + IMG_W;
  localparam bit REDUCE = ATOM_SLOTS < (1 << IDX_W);
  localparam logic signed [BW-1:0] BIAS = BW'(1) <<< (IFB - 1);

  state_t state, state_next;
  mstep_t step, step_tag;

  // configuration
  logic                    triclinic_mode;
  logic [GRP_W-1:0]        group_select;
  logic [LEN_W-1:0]        box_len_x, box_len_y, box_len_z;
  logic signed [POS_W-1:0] tilt_xy, tilt_xz, tilt_yz;

  // request
  logic                    cmd_r, sel_r, qneg_r;
  logic [IDX_W-1:0]        idx_r, slot_r;
  logic signed [POS_W-1:0] px_r, py_r, pz_r;
  logic signed [BW-1:0]    bx, by, bz;
  logic [CHG_W-1:0]        aq;
  logic [SCW-1:0]          scnt;
  logic [IXW-1:0]          img_ext;
  logic [CW-1:0]           slot_thr;

  // position store
  logic [3*POS_W-1:0] mem [ATOM_SLOTS];
  logic [3*POS_W-1:0] mem_q;
  logic [AW-1:0]      mem_addr;

  // multiplier and accumulators
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] prod;
  logic [2*MUL_W-1:0]        produ;
  logic [61:0]               vtmp;
  logic [VOL_W-1:0]          vol;
  logic signed [DW-1:0]      dx, dy, dz;
  logic [DMW-1:0]            ad [3];
  logic                      dneg [3];
  logic [PW-1:0]             pnum [4];
  logic [SW-1:0]             sum;

  // square root
  logic [LW+1:0] rrem, r_sh, r_trial;
  logic [LW-1:0] root;
  logic [RCW-1:0] rcnt;

  // dividers
  logic [RW-1:0]    drem [4];
  logic [RW-1:0]    div_sh [4];
  logic [6:0]       dfeed [4];
  logic [QW-1:0]    dq [4];
  logic             dcap [4];
  logic             dnz [4];
  logic [DCW-1:0]   dcnt;
  logic [OUT_W-1:0] mag [4];
  logic [OUT_W-1:0] sval [3];

  assign busy     = state != S_IDLE;
  assign mem_addr = AW'(slot_r);
  assign img_ext  = IXW'(image_word);
  assign slot_thr = CW'(ATOM_SLOTS) << scnt;
  assign produ    = prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      triclinic_mode <= 1'b0;
      group_select   <= 32'd1;
      box_len_x      <= 31'd65536;
      box_len_y      <= 31'd65536;
      box_len_z      <= 31'd65536;
      tilt_xy        <= '0;
      tilt_xz        <= '0;
      tilt_yz        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TRICLINIC:    triclinic_mode <= cfg_data[0];
        REG_GROUP_SELECT: group_select   <= cfg_data;
        REG_BOX_X:        box_len_x      <= cfg_data[LEN_W-1:0];
        REG_BOX_Y:        box_len_y      <= cfg_data[LEN_W-1:0];
        REG_BOX_Z:        box_len_z      <= cfg_data[LEN_W-1:0];
        REG_TILT_XY:      tilt_xy        <= $signed(cfg_data);
        REG_TILT_XZ:      tilt_xz        <= $signed(cfg_data);
        REG_TILT_YZ:      tilt_yz        <= $signed(cfg_data);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_LOAD && !cmd_r) begin
      mem[mem_addr] <= {pz_r, py_r, px_r};
    end
    mem_q <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step     <= STP_VXY;
      step_tag <= STP_END;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= state == S_OUT;
      if (state == S_LOAD) begin
        step <= STP_VXY;
      end else if (state == S_MUL) begin
        step_tag <= step;
        if (step == STP_ROOT) begin
          step <= STP_LL;
        end else if (step != STP_END) begin
          step <= mstep_t'(step + 5'd1);
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (start) state_next = REDUCE ? S_SLOT : S_LOAD;
      S_SLOT: if (scnt == '0) state_next = S_LOAD;
      S_LOAD: begin
        if (!cmd_r) state_next = S_IDLE;
        else if (!sel_r) state_next = S_OUT;
        else state_next = S_MUL;
      end
      S_MUL: begin
        if (step == STP_ROOT) state_next = S_ROOT;
        else if (step == STP_END) state_next = S_DIV;
      end
      S_ROOT: if (rcnt == RCW'(LW - 1)) state_next = S_MUL;
      S_DIV: if (dcnt == DCW'(QW)) state_next = S_OUT;
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step)
      STP_VXY:  begin mul_a = MUL_W'(box_len_x);      mul_b = MUL_W'(box_len_y); end
      STP_DX:   begin mul_a = MUL_W'(bx);             mul_b = MUL_W'(box_len_x); end
      STP_V_LO: begin mul_a = MUL_W'(vtmp[30:0]);     mul_b = MUL_W'(box_len_z); end
      STP_V_HI: begin mul_a = MUL_W'(vtmp[61:31]);    mul_b = MUL_W'(box_len_z); end
      STP_DY:   begin mul_a = MUL_W'(by);             mul_b = MUL_W'(box_len_y); end
      STP_DZ:   begin mul_a = MUL_W'(bz);             mul_b = MUL_W'(box_len_z); end
      STP_TXY:  begin mul_a = MUL_W'(by);             mul_b = MUL_W'(tilt_xy);   end
      STP_TXZ:  begin mul_a = MUL_W'(bz);             mul_b = MUL_W'(tilt_xz);   end
      STP_TYZ:  begin mul_a = MUL_W'(bz);             mul_b = MUL_W'(tilt_yz);   end
      STP_QXL:  begin mul_a = MUL_W'(ad[0][H-1:0]);   mul_b = MUL_W'(aq); end
      STP_QXH:  begin mul_a = MUL_W'(ad[0][DMW-1:H]); mul_b = MUL_W'(aq); end
      STP_QYL:  begin mul_a = MUL_W'(ad[1][H-1:0]);   mul_b = MUL_W'(aq); end
      STP_QYH:  begin mul_a = MUL_W'(ad[1][DMW-1:H]); mul_b = MUL_W'(aq); end
      STP_QZL:  begin mul_a = MUL_W'(ad[2][H-1:0]);   mul_b = MUL_W'(aq); end
      STP_QZH:  begin mul_a = MUL_W'(ad[2][DMW-1:H]); mul_b = MUL_W'(aq); end
      STP_SXL:  begin mul_a = MUL_W'(ad[0][H-1:0]);   mul_b = MUL_W'(ad[0][H-1:0]);   end
      STP_SXM:  begin mul_a = MUL_W'(ad[0][H-1:0]);   mul_b = MUL_W'(ad[0][DMW-1:H]); end
      STP_SXH:  begin mul_a = MUL_W'(ad[0][DMW-1:H]); mul_b = MUL_W'(ad[0][DMW-1:H]); end
      STP_SYL:  begin mul_a = MUL_W'(ad[1][H-1:0]);   mul_b = MUL_W'(ad[1][H-1:0]);   end
      STP_SYM:  begin mul_a = MUL_W'(ad[1][H-1:0]);   mul_b = MUL_W'(ad[1][DMW-1:H]); end
      STP_SYH:  begin mul_a = MUL_W'(ad[1][DMW-1:H]); mul_b = MUL_W'(ad[1][DMW-1:H]); end
      STP_SZL:  begin mul_a = MUL_W'(ad[2][H-1:0]);   mul_b = MUL_W'(ad[2][H-1:0]);   end
      STP_SZM:  begin mul_a = MUL_W'(ad[2][H-1:0]);   mul_b = MUL_W'(ad[2][DMW-1:H]); end
      STP_SZH:  begin mul_a = MUL_W'(ad[2][DMW-1:H]); mul_b = MUL_W'(ad[2][DMW-1:H]); end
      STP_LL:   begin mul_a = MUL_W'(root[LH-1:0]);   mul_b = MUL_W'(aq); end
      STP_LH:   begin mul_a = MUL_W'(root[LW-1:LH]);  mul_b = MUL_W'(aq); end
      default:  begin mul_a = '0;                     mul_b = '0;         end
    endcase
  end

  assign r_sh    = {rrem[LW-1:0], sum[SW-1:SW-2]};
  assign r_trial = {root, 2'b01};

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      div_sh[l] = {drem[l][RW-2:0], dfeed[l][6]};
      if (!dnz[l]) mag[l] = '0;
      else if (dcap[l]) mag[l] = TOP63;
      else mag[l] = {1'b0, dq[l]};
    end
    for (int l = 0; l < 3; l++) begin
      if (dneg[l] ^ qneg_r) sval[l] = OUT_W'(0) - mag[l];
      else sval[l] = mag[l][OUT_W-1] ? MAX63 : mag[l];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      cmd_r  <= command;
      idx_r  <= atom_index;
      slot_r <= atom_index;
      scnt   <= SCW'(IDX_W - 1);
      px_r   <= pos_x;
      py_r   <= pos_y;
      pz_r   <= pos_z;
      bx     <= $signed({1'b0, img_ext[0 +: IFB]}) - BIAS;
      by     <= $signed({1'b0, img_ext[IFB +: IFB]}) - BIAS;
      bz     <= $signed({1'b0, img_ext[2*IFB +: IFB]}) - BIAS;
      qneg_r <= charge[CHG_W-1];
      aq     <= charge[CHG_W-1] ? CHG_W'(-charge) : CHG_W'(charge);
      sel_r  <= |(atom_groups & group_select);
    end

    // index taken modulo the slot count, one binary digit per cycle
    if (state == S_SLOT) begin
      if (CW'(slot_r) >= slot_thr) begin
        slot_r <= IDX_W'(CW'(slot_r) - slot_thr);
      end
      scnt <= scnt - SCW'(1);
    end

    if (state == S_MUL) begin
      prod <= mul_a * mul_b;
      if (step == STP_VXY) begin
        dx   <= DW'(px_r) - DW'($signed(mem_q[POS_W-1:0]));
        dy   <= DW'(py_r) - DW'($signed(mem_q[2*POS_W-1:POS_W]));
        dz   <= DW'(pz_r) - DW'($signed(mem_q[3*POS_W-1:2*POS_W]));
        sum  <= '0;
        rrem <= '0;
        root <= '0;
        rcnt <= '0;
        dcnt <= '0;
        for (int l = 0; l < 4; l++) pnum[l] <= '0;
      end
      if (step == STP_MAG) begin
        ad[0]   <= dx[DW-1] ? DMW'(-dx) : DMW'(dx);
        ad[1]   <= dy[DW-1] ? DMW'(-dy) : DMW'(dy);
        ad[2]   <= dz[DW-1] ? DMW'(-dz) : DMW'(dz);
        dneg[0] <= dx[DW-1];
        dneg[1] <= dy[DW-1];
        dneg[2] <= dz[DW-1];
      end
      unique case (step_tag)
        STP_VXY:  vtmp <= produ[61:0];
        STP_DX:   dx <= dx + DW'(prod);
        STP_V_LO: vol <= VOL_W'(produ[61:0]);
        STP_V_HI: vol <= vol + (VOL_W'(produ[61:0]) << 31);
        STP_DY:   dy <= dy + DW'(prod);
        STP_DZ:   dz <= dz + DW'(prod);
        STP_TXY:  if (triclinic_mode) dx <= dx + DW'(prod);
        STP_TXZ:  if (triclinic_mode) dx <= dx + DW'(prod);
        STP_TYZ:  if (triclinic_mode) dy <= dy + DW'(prod);
        STP_QXL:  pnum[0] <= pnum[0] + PW'(produ);
        STP_QXH:  pnum[0] <= pnum[0] + (PW'(produ) << H);
        STP_QYL:  pnum[1] <= pnum[1] + PW'(produ);
        STP_QYH:  pnum[1] <= pnum[1] + (PW'(produ) << H);
        STP_QZL:  pnum[2] <= pnum[2] + PW'(produ);
        STP_QZH:  pnum[2] <= pnum[2] + (PW'(produ) << H);
        STP_SXL, STP_SYL, STP_SZL: sum <= sum + SW'(produ);
        STP_SXM, STP_SYM, STP_SZM: sum <= sum + (SW'(produ) << (H + 1));
        STP_SXH, STP_SYH, STP_SZH: sum <= sum + (SW'(produ) << (2 * H));
        STP_LL:   pnum[3] <= pnum[3] + PW'(produ);
        STP_LH:   pnum[3] <= pnum[3] + (PW'(produ) << LH);
        default:  ;
      endcase
    end

    // restoring square root, two radicand bits per cycle
    if (state == S_ROOT) begin
      if (r_sh >= r_trial) begin
        rrem <= r_sh - r_trial;
        root <= {root[LW-2:0], 1'b1};
      end else begin
        rrem <= r_sh;
        root <= {root[LW-2:0], 1'b0};
      end
      sum  <= sum << 2;
      rcnt <= rcnt + RCW'(1);
    end

    // The numerator is the product shifted up by 56. Its part from bit 63 upward
    // settles saturation; the remaining bits are fed in one per cycle.
    if (state == S_DIV) begin
      for (int l = 0; l < 4; l++) begin
        if (dcnt == '0) begin
          drem[l]  <= RW'(pnum[l][PW-1:7]);
          dfeed[l] <= pnum[l][6:0];
          dcap[l]  <= RW'(pnum[l][PW-1:7]) >= RW'(vol);
          dnz[l]   <= |pnum[l];
          dq[l]    <= '0;
        end else begin
          if (div_sh[l] >= RW'(vol)) begin
            drem[l] <= div_sh[l] - RW'(vol);
            dq[l]   <= {dq[l][QW-2:0], 1'b1};
          end else begin
            drem[l] <= div_sh[l];
            dq[l]   <= {dq[l][QW-2:0], 1'b0};
          end
          dfeed[l] <= {dfeed[l][5:0], 1'b0};
        end
      end
      dcnt <= dcnt + DCW'(1);
    end

    if (state == S_OUT) begin
      out_index <= idx_r;
      if (sel_r) begin
        qdisp_x   <= $signed(sval[0]);
        qdisp_y   <= $signed(sval[1]);
        qdisp_z   <= $signed(sval[2]);
        qdisp_len <= mag[3][OUT_W-1] ? MAX63[OUT_W-2:0] : mag[3][OUT_W-2:0];
      end else begin
        qdisp_x   <= '0;
        qdisp_y   <= '0;
        qdisp_z   <= '0;
        qdisp_len <= '0;
      end
    end
  end

endmodule

FILE: hdl/cwd_check.sv
module cwd_check (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic command,
  input logic done
);

  // A result only appears once the block has gone back to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  a_record_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !command) |=> !done ##1 !done)
    else $error("record request produced a result");

  a_reset: assert property (@(posedge clk) rst |=> (!busy && !done))
    else $error("block not idle after reset");

endmodule

bind charge_weighted_displacement cwd_check u_cwd_check (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .command(command),
  .done   (done)
);

FILE: dv/tb.sv
module tb;
  import cwd_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]        idx;
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
    logic [OUT_W-2:0]        len;
  } disp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic command = 1'b0;
  logic [IDX_W-1:0] atom_index = '0;
  logic signed [POS_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic [IMG_W-1:0] image_word = '0;
  logic signed [CHG_W-1:0] charge = '0;
  logic [GRP_W-1:0] atom_groups = '0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic done;
  logic [IDX_W-1:0] out_index;
  logic signed [OUT_W-1:0] qdisp_x, qdisp_y, qdisp_z;
  logic [OUT_W-2:0] qdisp_len;

  charge_weighted_displacement u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .atom_index(atom_index), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .image_word(image_word), .charge(charge), .atom_groups(atom_groups),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .out_index(out_index), .qdisp_x(qdisp_x), .qdisp_y(qdisp_y),
    .qdisp_z(qdisp_z), .qdisp_len(qdisp_len)
  );

  always #6 clk = ~clk;

  // Shadow of the block's registers and original position store.
  logic        sh_triclinic;
  logic [31:0] sh_groups;
  logic [30:0] sh_box_x, sh_box_y, sh_box_z;
  logic [31:0] sh_tilt_xy, sh_tilt_xz, sh_tilt_yz;
  logic [31:0] orig_x [ATOM_SLOTS_DEF];
  logic [31:0] orig_y [ATOM_SLOTS_DEF];
  logic [31:0] orig_z [ATOM_SLOTS_DEF];
  int          recorded_slots[$];
  bit          slot_recorded [ATOM_SLOTS_DEF];

  disp_t pending_disp[$];
  int mismatches = 0;
  int results_seen = 0;
  int records_sent = 0;
  int computes_sent = 0;
  bit allow_idle = 1'b1;

  function automatic logic [63:0] scaled_div(input logic [63:0] a, input logic [63:0] b,
                                             input logic [191:0] vol);
    logic [191:0] num;
    logic [191:0] quo;
    num = (192'(a) * 192'(b)) << 56;
    if (vol == 0) return (num == 0) ? 64'd0 : TOP63;
    quo = num / vol;
    if (quo >= (192'(1) << 63)) return TOP63;
    return quo[63:0];
  endfunction

  function automatic logic [63:0] signed_value(input logic [63:0] mag, input bit neg);
    if (neg) return 64'd0 - mag;
    return (mag > MAX63) ? MAX63 : mag;
  endfunction

  function automatic logic [63:0] abs64(input longint v);
    return (v < 0) ? 64'd0 - 64'(v) : 64'(v);
  endfunction

  function automatic disp_t predict_displacement(input logic [IDX_W-1:0] idx,
      input logic [31:0] px, input logic [31:0] py, input logic [31:0] pz,
      input logic [29:0] img, input logic [23:0] q, input logic [31:0] grp);
    disp_t r;
    longint bx, by, bz, dx, dy, dz, qs;
    logic [63:0] ax, ay, az, aq, root, cand;
    logic [191:0] vol;
    logic [127:0] sumsq;
    r = '0;
    r.idx = idx;
    if ((grp & sh_groups) == 0) return r;
    bx = longint'(img[9:0]) - 512;
    by = longint'(img[19:10]) - 512;
    bz = longint'(img[29:20]) - 512;
    dx = longint'($signed(px)) + bx * longint'(sh_box_x);
    dy = longint'($signed(py)) + by * longint'(sh_box_y);
    dz = longint'($signed(pz)) + bz * longint'(sh_box_z);
    if (sh_triclinic) begin
      dx += by * longint'($signed(sh_tilt_xy)) + bz * longint'($signed(sh_tilt_xz));
      dy += bz * longint'($signed(sh_tilt_yz));
    end
    dx -= longint'($signed(orig_x[idx]));
    dy -= longint'($signed(orig_y[idx]));
    dz -= longint'($signed(orig_z[idx]));
    qs = longint'($signed(q));
    vol = 192'(sh_box_x) * 192'(sh_box_y) * 192'(sh_box_z);
    aq = abs64(qs);
    ax = abs64(dx);
    ay = abs64(dy);
    az = abs64(dz);
    r.x = signed_value(scaled_div(ax, aq, vol), (dx < 0) != (qs < 0));
    r.y = signed_value(scaled_div(ay, aq, vol), (dy < 0) != (qs < 0));
    r.z = signed_value(scaled_div(az, aq, vol), (dz < 0) != (qs < 0));
    sumsq = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay) + 128'(az) * 128'(az);
    root = 0;
    for (int k = 62; k >= 0; k--) begin
      cand = root | (64'd1 << k);
      if (128'(cand) * 128'(cand) <= sumsq) root = cand;
    end
    cand = scaled_div(root, aq, vol);
    r.len = (cand > MAX63) ? MAX63[62:0] : cand[62:0];
    return r;
  endfunction

  always @(posedge clk) begin
    disp_t e;
    if (!rst && done) begin
      results_seen++;
      if (pending_disp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result for slot %0d", out_index);
      end else begin
        e = pending_disp.pop_front();
        if (out_index !== e.idx || qdisp_x !== e.x || qdisp_y !== e.y ||
            qdisp_z !== e.z || qdisp_len !== e.len) begin
          mismatches++;
          if (mismatches <= 10)
            $display("slot %0d: expected %h %h %h %h, got %0d %h %h %h %h", e.idx,
                     e.x, e.y, e.z, e.len, out_index, qdisp_x, qdisp_y, qdisp_z, qdisp_len);
        end
      end
    end
  end

  task automatic send_req(input bit cmd, input int idx, input logic [31:0] px,
      input logic [31:0] py, input logic [31:0] pz, input logic [29:0] img,
      input logic [23:0] q, input logic [31:0] grp);
    command     <= cmd;
    atom_index  <= idx[IDX_W-1:0];
    pos_x       <= px;
    pos_y       <= py;
    pos_z       <= pz;
    image_word  <= img;
    charge      <= q;
    atom_groups <= grp;
    start       <= 1'b1;
    do @(posedge clk); while (busy);
    if (cmd) begin
      pending_disp.push_back(predict_displacement(idx[IDX_W-1:0], px, py, pz, img, q, grp));
      computes_sent++;
    end else begin
      orig_x[idx] = px;
      orig_y[idx] = py;
      orig_z[idx] = pz;
      if (!slot_recorded[idx]) recorded_slots.push_back(idx);
      slot_recorded[idx] = 1'b1;
      records_sent++;
    end
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // Drains every outstanding request so the registers can be written safely.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_disp.size() != 0 || busy) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (r)
      REG_TRICLINIC:    sh_triclinic = v[0];
      REG_GROUP_SELECT: sh_groups = v;
      REG_BOX_X:        sh_box_x = v[30:0];
      REG_BOX_Y:        sh_box_y = v[30:0];
      REG_BOX_Z:        sh_box_z = v[30:0];
      REG_TILT_XY:      sh_tilt_xy = v;
      REG_TILT_XZ:      sh_tilt_xz = v;
      REG_TILT_YZ:      sh_tilt_yz = v;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_scaled();
    logic [31:0] v;
    v = $urandom >> $urandom_range(0, 31);
    return $urandom_range(0, 1) ? 32'd0 - v : v;
  endfunction

  task automatic write_box(input logic [31:0] lx, input logic [31:0] ly,
                           input logic [31:0] lz);
    write_reg(REG_BOX_X, lx);
    write_reg(REG_BOX_Y, ly);
    write_reg(REG_BOX_Z, lz);
  endtask

  task automatic test_directed();
    localparam logic [29:0] NO_IMAGE = {10'd512, 10'd512, 10'd512};
    send_req(1'b0, 0, 32'd0, 32'd0, 32'd0, 30'd0, 24'd0, 32'd0);
    send_req(1'b0, 1023, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, 24'h7FFFFF, '1);
    send_req(1'b0, 5, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 30'd0, 24'h800000, 32'd0);
    send_req(1'b1, 0, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, NO_IMAGE, 24'h010000, 32'd1);
    send_req(1'b1, 0, 32'd0, 32'd0, 32'd0, NO_IMAGE, 24'h7FFFFF, 32'd1);
    send_req(1'b1, 1023, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 30'd0, 24'h800000, 32'd1);
    send_req(1'b1, 5, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, 24'h7FFFFF, '1);
    // An atom outside the selected groups gives zeros but keeps its slot.
    send_req(1'b1, 5, 32'h1234_5678, 32'd1, 32'd2, NO_IMAGE, 24'h012345, 32'hFFFF_FFFE);
    send_req(1'b1, 1023, 32'h7FFF_0000, 32'h7FFF_0000, 32'h7FFF_0000, NO_IMAGE, 24'd0, 32'd1);
    settle();
    write_reg(REG_GROUP_SELECT, '1);
    write_reg(REG_TRICLINIC, 32'd1);
    write_reg(REG_TILT_XY, 32'h7FFF_FFFF);
    write_reg(REG_TILT_XZ, 32'h8000_0000);
    write_reg(REG_TILT_YZ, 32'h7FFF_FFFF);
    write_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_req(1'b1, 0, 32'h0000_1000, 32'd0, 32'd0, '1, 24'h7FFFFF, 32'h8000_0000);
    send_req(1'b1, 5, 32'd0, 32'd0, 32'd0, 30'd0, 24'h800000, 32'h0000_0100);
    send_req(1'b1, 1023, 32'd7, 32'd9, 32'd11, NO_IMAGE, 24'h000001, 32'd1);
    settle();
    // Zero volume: nonzero numerators saturate, zero ones stay zero.
    write_box(32'd0, 32'd65536, 32'd65536);
    send_req(1'b1, 0, 32'h0001_0000, 32'd0, 32'hFFFF_0000, NO_IMAGE, 24'h010000, 32'd1);
    send_req(1'b1, 0, 32'd0, 32'd0, 32'd0, NO_IMAGE, 24'h010000, 32'd1);
    settle();
    write_box(32'd1, 32'd1, 32'd1);
    send_req(1'b1, 5, 32'h8000_0001, 32'd3, 32'd0, NO_IMAGE, 24'h7FFFFF, 32'd1);
    settle();
  endtask

  // About a quarter of requests record a random slot. Most compute requests are
  // displacements near the recorded original with few image crossings; the rest use arbitrary field values.
  task automatic random_phase(input int n);
    int slot;
    logic [29:0] img;
    logic [31:0] px, py, pz;
    for (int i = 0; i < n; i++) begin
      if (recorded_slots.size() == 0 || $urandom_range(0, 3) == 0) begin
        slot = $urandom_range(0, 1023);
        send_req(1'b0, slot, rand_scaled(), rand_scaled(), rand_scaled(), 30'($urandom),
                 24'($urandom), $urandom);
      end else begin
        slot = recorded_slots[$urandom_range(0, recorded_slots.size() - 1)];
        if ($urandom_range(0, 9) < 6) begin
          img = {10'(512 + $urandom_range(0, 4) - 2), 10'(512 + $urandom_range(0, 4) - 2),
                 10'(512 + $urandom_range(0, 4) - 2)};
          px = orig_x[slot] + (rand_scaled() >>> 8);
          py = orig_y[slot] + (rand_scaled() >>> 8);
          pz = orig_z[slot] + (rand_scaled() >>> 8);
        end else begin
          img = 30'($urandom);
          px = rand_scaled();
          py = rand_scaled();
          pz = rand_scaled();
        end
        send_req(1'b1, slot, px, py, pz, img, 24'(rand_scaled()),
                 $urandom_range(0, 7) == 0 ? 32'd0 : $urandom);
      end
    end
    settle();
  endtask

  task automatic random_config();
    write_reg(REG_TRICLINIC, $urandom);
    write_reg(REG_GROUP_SELECT, $urandom_range(0, 3) == 0 ? $urandom : 32'hFFFF_FFFF);
    write_box(32'($urandom_range(1, 1 << 24)), 32'($urandom_range(1, 1 << 24)),
              32'($urandom_range(1, 1 << 24)));
    write_reg(REG_TILT_XY, rand_scaled());
    write_reg(REG_TILT_XZ, rand_scaled());
    write_reg(REG_TILT_YZ, rand_scaled());
  endtask

  task automatic test_orthogonal_random();
    write_reg(REG_TRICLINIC, 32'd0);
    write_reg(REG_GROUP_SELECT, 32'hFFFF_FFFF);
    write_box(32'd65536 << 4, 32'd65536 << 5, 32'd65536 << 6);
    random_phase(450);
  endtask

  task automatic test_triclinic_random();
    for (int p = 0; p < 4; p++) begin
      random_config();
      random_phase(220);
    end
  endtask

  task automatic test_extreme_boxes();
    write_reg(REG_TRICLINIC, 32'd1);
    write_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    random_phase(150);
    write_box(32'd1, 32'd1, 32'd1);
    write_reg(REG_GROUP_SELECT, 32'd1);
    random_phase(150);
  endtask

  task automatic test_back_to_back();
    allow_idle = 1'b0;
    random_config();
    random_phase(200);
  endtask

  initial begin
    sh_triclinic = 1'b0;
    sh_groups    = 32'd1;
    sh_box_x     = 31'd65536;
    sh_box_y     = 31'd65536;
    sh_box_z     = 31'd65536;
    sh_tilt_xy   = '0;
    sh_tilt_xz   = '0;
    sh_tilt_yz   = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_orthogonal_random();
    test_triclinic_random();
    test_extreme_boxes();
    test_back_to_back();
    settle();
    repeat (200) @(posedge clk);
    $display("covered %0d record and %0d compute requests, %0d results checked",
             records_sent, computes_sent, results_seen);
    $display("orthogonal, triclinic, zero-volume, saturating and unselected cases exercised");
    if (mismatches == 0 && pending_disp.size() == 0) begin
      $display("charge_weighted_displacement: match");
    end else begin
      $display("charge_weighted_displacement: mismatch");
    end
    $finish;
  end

  initial begin
    #(12 * 6_000_000);
    $display("timeout");
    $display("charge_weighted_displacement: mismatch");
    $finish;
  end

endmodule
